// ===== rtl/core/sref_pkg.sv =====
package sref_pkg;

	localparam int DIR_FRAC_BITS = 14;
	localparam int ONE           = 1 << DIR_FRAC_BITS;
	localparam int ETA_ONE       = 4096;
	localparam logic [14:0] ETA_RESET = 15'd6144;

	// Stage plan of the pipeline. Each unit retires one root or quotient bit per stage.
	localparam int S_INIT    = 1;
	localparam int S_PROD    = 2;
	localparam int ST_FIRST  = 3;                  // 15 stages
	localparam int VX_FIRST  = 3;                  // 28 stages
	localparam int R0_FIRST  = 4;                  // 17 stages
	localparam int S_R0MUL   = R0_FIRST + 17;
	localparam int S_REFL    = S_R0MUL + 1;
	localparam int S_SIMUL   = ST_FIRST + 15;
	localparam int S_TIR     = S_SIMUL + 1;
	localparam int SI_FIRST  = S_TIR + 1;          // DIR_FRAC_BITS stages
	localparam int S_CIARG   = SI_FIRST + DIR_FRAC_BITS;
	localparam int CI_FIRST  = S_CIARG + 1;        // 15 stages
	localparam int S_SQ      = CI_FIRST + 15;
	localparam int S_SUM     = S_SQ + 1;
	localparam int LN_FIRST  = S_SUM + 1;          // 28 stages
	localparam int S_ONUM    = LN_FIRST + 28;
	localparam int O_FIRST   = S_ONUM + 1;         // 15 stages
	localparam int LAST      = O_FIRST + 14;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} dir_t;

	typedef struct packed {
		logic signed [15:0] new_x;
		logic signed [15:0] new_y;
		logic signed [15:0] new_z;
		logic               total_internal;
		logic [15:0]        fresnel_reflectance;
	} res_t;

	typedef struct packed {
		logic [55:0] rem;
		logic [55:0] root;
	} sq_t;

	typedef struct packed {
		logic [46:0] rem;
		logic [27:0] quo;
	} dv_t;

	typedef struct packed {
		logic signed [15:0] xr;
		logic signed [15:0] yr;
		logic signed [15:0] zr;
		logic               x_pos;
		logic               z_pos;
		logic               ent;
		logic               tir;
		logic [14:0]        n;
		logic [14:0]        num;
		logic [14:0]        den;
		logic [14:0]        ay;
		logic [15:0]        ax;
		logic [15:0]        az;
		logic [14:0]        d;
		logic [16:0]        m;
		logic [16:0]        p;
		logic [33:0]        pr;
		logic [30:0]        nd;
		logic [29:0]        dd;
		logic [15:0]        refl;
		sq_t                st;
		sq_t                ci;
		sq_t                ln;
		dv_t                si;
		dv_t                vx;
		dv_t                vz;
		dv_t                ox;
		dv_t                oy;
		dv_t                oz;
		dv_t                r0;
		logic [55:0]        sqx;
		logic [55:0]        sqz;
		logic [55:0]        sqc;
	} work_t;

	function automatic sq_t sqrt_step(input int k, input sq_t s);
		logic [55:0] bitv;
		logic [55:0] trial;
		sq_t o;
		bitv  = 56'd1 << (2 * k);
		trial = s.root + bitv;
		o     = s;
		if (s.rem >= trial) begin
			o.rem  = s.rem - trial;
			o.root = (s.root >> 1) + bitv;
		end else begin
			o.root = s.root >> 1;
		end
		return o;
	endfunction

	function automatic dv_t div_step(input int k, input dv_t s, input logic [31:0] den);
		logic [46:0] sh;
		dv_t o;
		sh = 47'(den) << k;
		o  = s;
		if (s.rem >= sh) begin
			o.rem    = s.rem - sh;
			o.quo[k] = 1'b1;
		end
		return o;
	endfunction

	function automatic logic [16:0] round16(input logic [33:0] v);
		logic [33:0] t;
		t = (v + 34'd32768) >> 16;
		return t[16:0];
	endfunction

	function automatic logic [15:0] mag16(input logic signed [15:0] v);
		return v[15] ? 16'(-v) : 16'(v);
	endfunction

	function automatic work_t init_work(input dir_t di, input logic [14:0] eta);
		logic [15:0] ymag;
		logic [47:0] tm;
		work_t w;
		w       = '0;
		w.xr    = di.dir_x;
		w.yr    = di.dir_y;
		w.zr    = di.dir_z;
		w.n     = (eta == 15'd0) ? 15'd1 : eta;
		w.ent   = di.dir_y[15];
		w.num   = w.ent ? w.n : 15'(ETA_ONE);
		w.den   = w.ent ? 15'(ETA_ONE) : w.n;
		ymag    = mag16(di.dir_y);
		w.ay    = (ymag > 16'(ONE)) ? 15'(ONE) : ymag[14:0];
		w.ax    = mag16(di.dir_x);
		w.az    = mag16(di.dir_z);
		w.x_pos = !di.dir_x[15] && (di.dir_x != 16'sd0);
		w.z_pos = !di.dir_z[15] && (di.dir_z != 16'sd0);
		w.d     = (w.n > 15'(ETA_ONE)) ? w.n - 15'(ETA_ONE) : 15'(ETA_ONE) - w.n;
		tm      = ((48'(ONE) - 48'(w.ay)) << 16) + 48'(ONE / 2);
		w.m     = 17'(tm >> DIR_FRAC_BITS);
		return w;
	endfunction

	function automatic work_t stage_step(input int i, input work_t w);
		logic [15:0] s16;
		logic [46:0] h;
		logic [17:0] t;
		work_t o;
		o = w;
		if (i == S_PROD) begin
			o.st.rem  = (56'(ONE) << DIR_FRAC_BITS) - 56'(w.ay) * 56'(w.ay);
			o.st.root = '0;
			o.vx.rem  = 47'(w.ax) * 47'(w.num) + 47'(w.den >> 1);
			o.vx.quo  = '0;
			o.vz.rem  = 47'(w.az) * 47'(w.num) + 47'(w.den >> 1);
			o.vz.quo  = '0;
			s16       = 16'(w.n) + 16'(ETA_ONE);
			o.nd      = 31'(32'(s16) * 32'(s16));
			o.dd      = 30'(w.d) * 30'(w.d);
			o.pr      = 34'(w.m) * 34'(w.m);
		end
		if (i == S_PROD + 1) begin
			o.r0.rem = {1'b0, w.dd, 16'd0} + 47'(w.nd >> 1);
			o.r0.quo = '0;
			o.p      = round16(w.pr);
		end
		if (i == S_PROD + 2) o.pr = 34'(w.p) * 34'(w.p);
		if (i == S_PROD + 3) o.p = round16(w.pr);
		if (i == S_PROD + 4) o.pr = 34'(w.p) * 34'(w.m);
		if (i == S_PROD + 5) o.p = round16(w.pr);
		if (i >= R0_FIRST && i < R0_FIRST + 17)
			o.r0 = div_step(R0_FIRST + 16 - i, w.r0, 32'(w.nd));
		if (i == S_R0MUL) o.pr = 34'(17'h10000 - w.r0.quo[16:0]) * 34'(w.p);
		if (i == S_REFL) begin
			// A reflectance at base of one leaves no room for the Schlick term.
			t      = 18'(w.r0.quo[16:0]) + (w.r0.quo[16] ? 18'd0 : 18'(round16(w.pr)));
			o.refl = (t > 18'd65535) ? 16'hFFFF : t[15:0];
		end
		if (i >= ST_FIRST && i < ST_FIRST + 15)
			o.st = sqrt_step(ST_FIRST + 14 - i, w.st);
		if (i >= VX_FIRST && i < VX_FIRST + 28) begin
			o.vx = div_step(VX_FIRST + 27 - i, w.vx, 32'(w.den));
			o.vz = div_step(VX_FIRST + 27 - i, w.vz, 32'(w.den));
		end
		if (i == S_SIMUL) begin
			o.si.rem = 47'(w.st.root[14:0]) * 47'(w.num);
			o.si.quo = '0;
		end
		if (i == S_TIR) o.tir = w.si.rem >= (47'(w.den) << DIR_FRAC_BITS);
		if (i >= SI_FIRST && i < SI_FIRST + DIR_FRAC_BITS)
			o.si = div_step(SI_FIRST + DIR_FRAC_BITS - 1 - i, w.si, 32'(w.den));
		if (i == S_CIARG) begin
			o.ci.rem  = (56'(ONE) << DIR_FRAC_BITS)
				- 56'(w.si.quo[13:0]) * 56'(w.si.quo[13:0]);
			o.ci.root = '0;
		end
		if (i >= CI_FIRST && i < CI_FIRST + 15)
			o.ci = sqrt_step(CI_FIRST + 14 - i, w.ci);
		if (i == S_SQ) begin
			o.sqx = 56'(w.vx.quo) * 56'(w.vx.quo);
			o.sqz = 56'(w.vz.quo) * 56'(w.vz.quo);
			o.sqc = 56'(w.ci.root[14:0]) * 56'(w.ci.root[14:0]);
		end
		if (i == S_SUM) begin
			o.ln.rem  = w.sqx + w.sqz + w.sqc;
			o.ln.root = '0;
		end
		if (i >= LN_FIRST && i < LN_FIRST + 28)
			o.ln = sqrt_step(LN_FIRST + 27 - i, w.ln);
		if (i == S_ONUM) begin
			h        = 47'(w.ln.root[27:0] >> 1);
			o.ox.rem = (47'(w.vx.quo) << DIR_FRAC_BITS) + h;
			o.oy.rem = (47'(w.ci.root[14:0]) << DIR_FRAC_BITS) + h;
			o.oz.rem = (47'(w.vz.quo) << DIR_FRAC_BITS) + h;
			o.ox.quo = '0;
			o.oy.quo = '0;
			o.oz.quo = '0;
		end
		if (i >= O_FIRST && i < O_FIRST + 15) begin
			o.ox = div_step(O_FIRST + 14 - i, w.ox, 32'(w.ln.root[27:0]));
			o.oy = div_step(O_FIRST + 14 - i, w.oy, 32'(w.ln.root[27:0]));
			o.oz = div_step(O_FIRST + 14 - i, w.oz, 32'(w.ln.root[27:0]));
		end
		return o;
	endfunction

	function automatic logic signed [15:0] pack_dir(input logic neg, input logic [14:0] mag);
		return neg ? 16'(-$signed({1'b0, mag})) : $signed({1'b0, mag});
	endfunction

	function automatic res_t format_result(input work_t w);
		res_t r;
		r.fresnel_reflectance = w.refl;
		r.total_internal      = w.tir;
		if (w.tir) begin
			r.new_x = 16'(-w.xr);
			r.new_y = w.yr;
			r.new_z = 16'(-w.zr);
		end else if (w.ln.root[27:0] == 28'd0) begin
			r.new_x = '0;
			r.new_y = '0;
			r.new_z = '0;
		end else begin
			// Refracted x and z point against the incoming x and z.
			r.new_x = pack_dir(w.x_pos, w.ox.quo[14:0]);
			r.new_y = pack_dir(!w.ent, w.oy.quo[14:0]);
			r.new_z = pack_dir(w.z_pos, w.oz.quo[14:0]);
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/snell_refraction_with_fresnel.sv =====
// Refracts one unit direction (normal +y) per clock and gives Schlick reflectance. A word is
// taken whenever start is high; busy is always low. The word passes LAST = 95 pipeline
// registers and the output register, which shows its result on the outputs with done high
// for one cycle. The depth of the pipeline is set by the bit-per-stage square roots and
// dividers in series (sin, the quotient that scales sin by eta or by one over eta, cos,
// the vector length and the normalisation).
// The receiver cannot stall, so the pipeline never holds. The index register may be written
// on the cfg channel at any time but should only change while no word is in flight.
module snell_refraction_with_fresnel import sref_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  dir_t        dir,
	output logic        done,
	output res_t        result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);

	logic [14:0]      eta_q;
	logic [LAST:1]    vld_s;
	work_t            pipe_s [1:LAST];
	logic             done_q;
	res_t             result_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_q  <= ETA_RESET;
			vld_s  <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				eta_q <= cfg_data;
			end
			vld_s  <= {vld_s[LAST-1:1], start && !busy};
			done_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		pipe_s[S_INIT] <= init_work(dir, eta_q);
		for (int g = S_PROD; g <= LAST; g++) begin
			pipe_s[g] <= stage_step(g, pipe_s[g-1]);
		end
		result_q       <= format_result(pipe_s[LAST]);
	end

	// Without total reflection sin stays below one, so cos is never zero.
	a_cos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[S_SQ] && !pipe_s[S_SQ].tir |-> pipe_s[S_SQ].ci.root != '0)
		else $error("cos of refracted ray is zero");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[S_ONUM] && !pipe_s[S_ONUM].tir |-> pipe_s[S_ONUM].ln.root != '0)
		else $error("refracted vector length is zero");

	// Every component is at most the length, so a normalised component never exceeds one.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAST] && !pipe_s[LAST].tir |->
		pipe_s[LAST].ox.quo <= 28'(ONE) && pipe_s[LAST].oy.quo <= 28'(ONE)
		&& pipe_s[LAST].oz.quo <= 28'(ONE))
		else $error("normalised component above one");

endmodule

// ===== verif/snell_refraction_with_fresnel_test.sv =====
module snell_refraction_with_fresnel_test;
	import sref_pkg::*;

	localparam int LATENCY   = 96;
	localparam int WATCH_MAX = 4000;

	class refraction_board;
		res_t expected_q[$];
		logic [14:0] eta;
		int errors;

		function new();
			eta = ETA_RESET;
			errors = 0;
		endfunction

		static function longint unsigned root_floor(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		static function longint unsigned q16_mul(longint unsigned a, longint unsigned b);
			return (a * b + 32768) >> 16;
		endfunction

		static function logic [15:0] to_signed16(bit neg, longint unsigned mg);
			if (neg) begin
				if (mg > 32768) mg = 32768;
				return 16'(-mg);
			end
			if (mg > 32767) mg = 32767;
			return 16'(mg);
		endfunction

		function void note_direction(dir_t d);
			longint signed x, y, z;
			longint unsigned one, n, num, den, ay, st, si, ci, vx, vz, ln;
			longint unsigned r0, m, p, refl, dl, nd;
			bit entering;
			res_t r;
			one = 64'd1 << DIR_FRAC_BITS;
			x = d.dir_x;
			y = d.dir_y;
			z = d.dir_z;
			n = (eta == 0) ? 1 : eta;
			entering = y < 0;
			num = entering ? n : ETA_ONE;
			den = entering ? ETA_ONE : n;
			ay = (y < 0) ? -y : y;
			if (ay > one) ay = one;
			dl = (n > ETA_ONE) ? n - ETA_ONE : ETA_ONE - n;
			nd = (n + ETA_ONE) * (n + ETA_ONE);
			r0 = (dl * dl * 65536 + nd / 2) / nd;
			m = ((one - ay) * 65536 + one / 2) >> DIR_FRAC_BITS;
			p = q16_mul(m, m);
			p = q16_mul(p, p);
			p = q16_mul(p, m);
			refl = r0 + (r0 < 65536 ? q16_mul(65536 - r0, p) : 0);
			if (refl > 65535) refl = 65535;
			r.fresnel_reflectance = refl[15:0];
			st = root_floor(one * one - ay * ay);
			si = st * num / den;
			if (si >= one) begin
				r.new_x = 16'(-x);
				r.new_y = 16'(y);
				r.new_z = 16'(-z);
				r.total_internal = 1'b1;
			end else begin
				ci = root_floor(one * one - si * si);
				vx = (((x < 0) ? -x : x) * num + den / 2) / den;
				vz = (((z < 0) ? -z : z) * num + den / 2) / den;
				ln = root_floor(vx * vx + ci * ci + vz * vz);
				r.total_internal = 1'b0;
				if (ln == 0) begin
					r.new_x = '0;
					r.new_y = '0;
					r.new_z = '0;
				end else begin
					r.new_x = to_signed16(x > 0, (vx * one + ln / 2) / ln);
					r.new_y = to_signed16(!entering, (ci * one + ln / 2) / ln);
					r.new_z = to_signed16(z > 0, (vz * one + ln / 2) / ln);
				end
			end
			expected_q.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t w;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			w = expected_q.pop_front();
			if (got.new_x !== w.new_x) begin
				$display("%0t: new_x expected %0d actual %0d", $time, w.new_x, got.new_x);
				errors++;
			end
			if (got.new_y !== w.new_y) begin
				$display("%0t: new_y expected %0d actual %0d", $time, w.new_y, got.new_y);
				errors++;
			end
			if (got.new_z !== w.new_z) begin
				$display("%0t: new_z expected %0d actual %0d", $time, w.new_z, got.new_z);
				errors++;
			end
			if (got.total_internal !== w.total_internal) begin
				$display("%0t: total_internal expected %0d actual %0d", $time,
					w.total_internal, got.total_internal);
				errors++;
			end
			if (got.fresnel_reflectance !== w.fresnel_reflectance) begin
				$display("%0t: fresnel_reflectance expected %0d actual %0d", $time,
					w.fresnel_reflectance, got.fresnel_reflectance);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done, cfg_valid, cfg_ready;
	dir_t dir;
	res_t result;
	logic [14:0] cfg_data;
	refraction_board board;
	int idle_pct;
	int quiet_cycles;

	snell_refraction_with_fresnel dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .dir(dir),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) board.check_result(result);
	end

	// Watchdog: counts cycles with no word moving in either direction.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_MAX) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Start stays high after a word so that the next one can follow in the very next cycle.
	task automatic send_direction(dir_t d);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		dir <= d;
		do @(posedge clk); while (busy);
		board.note_direction(d);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_index(logic [14:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.eta = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_component();
		case ($urandom_range(9))
			0: return 16'($urandom);
			1: return 16'sd16384;
			2: return -16'sd16384;
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	task automatic random_phase(int count, int pct);
		dir_t d;
		idle_pct = pct;
		repeat (count) begin
			d.dir_x = pick_component();
			d.dir_y = pick_component();
			d.dir_z = pick_component();
			send_direction(d);
		end
	endtask

	task automatic directed_set();
		dir_t d;
		logic signed [15:0] vals[8];
		vals = '{16'sd0, 16'sd16384, -16'sd16384, -16'sd32768, 16'sd32767,
			16'sd1, -16'sd1, 16'sd11585};
		idle_pct = 0;
		for (int i = 0; i < 8; i++) begin
			d.dir_x = vals[i];
			d.dir_y = vals[(i + 3) % 8];
			d.dir_z = vals[(i + 5) % 8];
			send_direction(d);
		end
		d = '0;
		send_direction(d);
		d.dir_x = -16'sd32768; d.dir_y = 16'sd1000; d.dir_z = -16'sd32768;
		send_direction(d);
		d.dir_x = 16'sd16000; d.dir_y = 16'sd2000; d.dir_z = 16'sd0;
		send_direction(d);
		d.dir_x = 16'sd16000; d.dir_y = -16'sd2000; d.dir_z = 16'sd0;
		send_direction(d);
	endtask

	initial begin
		logic [14:0] settings[6];
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		dir = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_set();
		random_phase(60, 0);
		drain();
		settings = '{15'd4096, 15'd32767, 15'd0, 15'd1, 15'd5461, 15'd6144};
		for (int s = 0; s < 6; s++) begin
			write_index(settings[s]);
			directed_set();
			random_phase(40, 49);
			random_phase(30, 32);
			random_phase(25, 0);
			drain();
		end
		write_index(15'($urandom_range(32767)));
		random_phase(60, 49);
		drain();
		if (board.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
